/* sv/rpc_pkg.sv */
// Shared types and constants for the centroid rotation block.
`default_nettype none
package rpc_pkg;
  localparam int CoordW = 16;
  localparam int SumW = 23;
  localparam int OutW = 22;
  localparam int DivW = 24;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_MUL,
    ST_EMIT_OUT
  } rpc_state_t;

  typedef enum logic {
    CFG_COS = 1'b0,
    CFG_SIN = 1'b1
  } rpc_cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic emit_rd;
    logic emit_mul;
    logic out_load;
    logic clear;
  } rpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic rd_last;
    logic empty;
  } rpc_sts_t;
endpackage
`default_nettype wire

/* sv/rpc_ctrl.sv */
// Controller state machine: load, divide, emit.
`default_nettype none
module rpc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output rpc_pkg::rpc_cmd_t    cmd,
  input  wire rpc_pkg::rpc_sts_t sts
);
  import rpc_pkg::*;

  rpc_state_t state, state_next;
  logic       out_full, out_full_next;
  logic       was_last, was_last_next;
  logic       in_acc;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_acc && in_last) state_next = ST_DIV;
      ST_DIV: begin
        if (sts.empty) state_next = ST_LOAD;
        else if (sts.div_done) state_next = ST_EMIT_RD;
      end
      ST_EMIT_RD: state_next = ST_EMIT_MUL;
      ST_EMIT_MUL: state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (!out_full || !out_stall) state_next = was_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != ST_LOAD);
    out_full_next = out_full && out_stall;
    was_last_next = was_last;
    unique case (state)
      ST_LOAD: cmd.load = in_acc;
      ST_DIV: begin
        cmd.div_start = 1'b0;
        cmd.clear = sts.empty;
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        was_last_next = sts.rd_last;
      end
      ST_EMIT_MUL: cmd.emit_mul = 1'b1;
      ST_EMIT_OUT: begin
        if (!out_full || !out_stall) begin
          cmd.out_load = 1'b1;
          out_full_next = 1'b1;
          cmd.clear = was_last;
        end
      end
      default: ;
    endcase
    if (state == ST_LOAD && in_acc && in_last) cmd.div_start = 1'b1;
  end

  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      out_full <= 1'b0;
      was_last <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
      was_last <= was_last_next;
    end
  end

  a_load_only: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ST_LOAD) else $error("load outside LOAD");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result lost");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> in_stall) else $error("accept while busy");
endmodule
`default_nettype wire

/* sv/rpc_dp.sv */
// Datapath: vertex store, sums, centroid divider, rotation and output register.
`default_nettype none
module rpc_dp #(
  parameter int MaxVertices = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_idx,
  input  wire logic signed [15:0]        cfg_data,
  input  wire logic signed [15:0]        x_in,
  input  wire logic signed [15:0]        y_in,
  input  wire rpc_pkg::rpc_cmd_t         cmd,
  output rpc_pkg::rpc_sts_t              sts,
  output logic signed [rpc_pkg::OutW-1:0] x_out,
  output logic signed [rpc_pkg::OutW-1:0] y_out,
  output logic                           last_out,
  output logic                           overflow
);
  import rpc_pkg::*;

  localparam int AddrW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CntW = $clog2(MaxVertices + 1);

  logic [31:0]            mem [MaxVertices];
  logic [31:0]            rd_data;
  logic signed [15:0]     cos_r, sin_r;
  logic signed [SumW-1:0] sum_x, sum_y;
  logic [CntW-1:0]        count, rd_ptr;
  logic                   dropped, full;

  // Restoring divider for both coordinates at once, with one shared step counter and divisor, one quotient bit a cycle.
  logic [DivW-1:0]        dq_x, dq_y, dr_x, dr_y;
  logic [4:0]             dstep;
  logic                   dbusy, neg_x, neg_y;
  logic [DivW:0]          tr_x, tr_y;
  logic signed [16:0]     cx, cy;
  logic [4:0]             dcnt;
  logic                   div_fin, extra_done;

  logic signed [17:0]     dx, dy;
  logic signed [35:0]     px_c, py_s, px_s, py_c;
  logic signed [37:0]     rx, ry;
  logic signed [38:0]     ox, oy;
  logic signed [28:0]     qx, qy;

  assign full = (count == CntW'(MaxVertices));

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_r <= 16'sd16384;
      sin_r <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_COS) cos_r <= cfg_data;
      else sin_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[count[AddrW-1:0]] <= {y_in, x_in};
    if (cmd.emit_rd) rd_data <= mem[rd_ptr[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum_x <= '0; sum_y <= '0; count <= '0; dropped <= 1'b0; rd_ptr <= '0;
    end else begin
      if (cmd.load) begin
        if (full) dropped <= 1'b1;
        else begin
          sum_x <= sum_x + SumW'(x_in);
          sum_y <= sum_y + SumW'(y_in);
          count <= count + 1'b1;
        end
      end
      if (cmd.emit_rd) rd_ptr <= rd_ptr + 1'b1;
    end
  end

  assign tr_x = {dr_x, dq_x[DivW-1]} - {{(DivW+1-CntW){1'b0}}, count};
  assign tr_y = {dr_y, dq_y[DivW-1]} - {{(DivW+1-CntW){1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dstep <= '0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
      dstep <= '0;
    end else if (dbusy) begin
      dstep <= dstep + 1'b1;
      if (dstep == 5'(DivW - 1)) dbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      // Sums including this request's vertex are not ready yet; load at step 0.
      dr_x <= '0; dr_y <= '0;
    end else if (dbusy && dstep == 5'd0) begin
      dr_x <= '0; dr_y <= '0;
      neg_x <= sum_x[SumW-1];
      neg_y <= sum_y[SumW-1];
      dq_x <= DivW'(sum_x[SumW-1] ? -sum_x : sum_x);
      dq_y <= DivW'(sum_y[SumW-1] ? -sum_y : sum_y);
    end else if (dbusy || (div_fin && !extra_done)) begin
      // One extra iteration after dbusy drops finishes the last quotient bit.
      if (!tr_x[DivW]) begin
        dr_x <= tr_x[DivW-1:0]; dq_x <= {dq_x[DivW-2:0], 1'b1};
      end else begin
        dr_x <= {dr_x[DivW-2:0], dq_x[DivW-1]}; dq_x <= {dq_x[DivW-2:0], 1'b0};
      end
      if (!tr_y[DivW]) begin
        dr_y <= tr_y[DivW-1:0]; dq_y <= {dq_y[DivW-2:0], 1'b1};
      end else begin
        dr_y <= {dr_y[DivW-2:0], dq_y[DivW-1]}; dq_y <= {dq_y[DivW-2:0], 1'b0};
      end
    end
  end

  // Step 0 loads the operands, steps 1..DivW-1 plus one extra produce bits.
  always_ff @(posedge clk) begin
    if (rst || cmd.div_start) dcnt <= '0;
    else if (dbusy && dstep != 5'd0) dcnt <= dcnt + 1'b1;
  end

  assign cx = neg_x ? -17'(dq_x) : 17'(dq_x);
  assign cy = neg_y ? -17'(dq_y) : 17'(dq_y);

  assign div_fin = !dbusy && !cmd.div_start && dcnt == 5'(DivW - 1);

  always_ff @(posedge clk) begin
    if (rst || cmd.div_start) extra_done <= 1'b0;
    else if (div_fin) extra_done <= 1'b1;
  end

  assign sts.div_done = extra_done;
  assign sts.empty = (count == '0);
  assign sts.rd_last = (rd_ptr + 1'b1 == count);

  assign dx = 18'(signed'(rd_data[15:0])) - 18'(cx);
  assign dy = 18'(signed'(rd_data[31:16])) - 18'(cy);

  always_ff @(posedge clk) begin
    if (cmd.emit_mul) begin
      px_c <= dx * cos_r;
      py_s <= dy * sin_r;
      px_s <= dx * sin_r;
      py_c <= dy * cos_r;
    end
  end

  assign rx = 38'(px_c) - 38'(py_s) + 38'sd512;
  assign ry = 38'(px_s) + 38'(py_c) + 38'sd512;
  assign qx = 29'(rx >>> 10);
  assign qy = 29'(ry >>> 10);
  assign ox = 39'(qx) + 39'(cx) * 39'sd16;
  assign oy = 39'(qy) + 39'(cy) * 39'sd16;

  function automatic logic signed [OutW-1:0] sat(input logic signed [38:0] v);
    logic signed [OutW-1:0] r;
    if (v > 39'sd2097151) r = {1'b0, {(OutW-1){1'b1}}};
    else if (v < -39'sd2097152) r = {1'b1, {(OutW-1){1'b0}}};
    else r = v[OutW-1:0];
    return r;
  endfunction

  logic last_pend;
  always_ff @(posedge clk) begin
    if (cmd.emit_rd) last_pend <= sts.rd_last;
    if (cmd.out_load) begin
      x_out <= sat(ox);
      y_out <= sat(oy);
      last_out <= last_pend;
      overflow <= dropped;
    end
  end

  a_div_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_rd |-> !dbusy) else $error("read during divide");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxVertices)) else $error("count beyond depth");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    cmd.load && full |=> dropped) else $error("drop not flagged");
endmodule
`default_nettype wire

/* sv/rotate_points_about_centroid_core.sv */
// Top level of the block that rotates a shape about its centroid.
// Vertices are taken one per cycle while loading; after the last one the centroid is divided,
// then each result passes through store read, multiply and output register in turn.
// While emitting, a result is read only after the previous one has entered the output register.
// The centroid divider produces one quotient bit per cycle for both axes at once.
// Reset (rst, synchronous) empties the shape and sets cos to 1.0 and sin to 0.
`default_nettype none
module rotate_points_about_centroid_core #(
  parameter int MaxVertices = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] x_in,
  input  wire logic signed [15:0] y_in,
  input  wire logic               last_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [21:0]      x_out,
  output logic signed [21:0]      y_out,
  output logic                    last_out,
  output logic                    overflow
);
  import rpc_pkg::*;

  rpc_cmd_t cmd;
  rpc_sts_t sts;

  rpc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_last(last_in), .in_stall,
    .out_valid, .out_stall, .cmd, .sts
  );

  rpc_dp #(.MaxVertices(MaxVertices)) u_dp (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data(signed'(cfg_data)),
    .x_in, .y_in, .cmd, .sts, .x_out, .y_out, .last_out, .overflow
  );
endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench for the centroid rotation block: directed and random shapes against a local predictor.
`default_nettype none
module tb;
  import rpc_pkg::*;

  localparam int MaxVerts = 64;
  localparam int CycleLimit = 2000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_idx;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] x_in;
  logic signed [15:0] y_in;
  logic last_in;
  logic out_valid;
  logic out_stall;
  logic signed [21:0] x_out;
  logic signed [21:0] y_out;
  logic last_out;
  logic overflow;

  rotate_points_about_centroid_core #(.MaxVertices(MaxVerts)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .x_in(x_in), .y_in(y_in), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall), .x_out(x_out), .y_out(y_out),
    .last_out(last_out), .overflow(overflow)
  );

  typedef struct packed {
    logic signed [21:0] x;
    logic signed [21:0] y;
    logic last;
    logic ovf;
  } rot_point_t;

  // Predictor state.
  logic signed [15:0] shape_x[MaxVerts];
  logic signed [15:0] shape_y[MaxVerts];
  int shape_n;
  longint acc_x, acc_y;
  bit shape_dropped;
  logic signed [15:0] cos_val, sin_val;

  rot_point_t rotated_q[$];
  int mismatches;
  int points_seen;
  int shapes_sent;
  int hold_cycles;
  bit rand_stall_en;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [21:0] sat22(longint v);
    if (v > 2097151) return 22'sh1fffff;
    if (v < -2097152) return 22'sh200000;
    return v[21:0];
  endfunction

  // Q.14 to Q.4 with a tie going toward plus infinity; >>> floors.
  function automatic longint q14_round(longint v);
    return (v + 512) >>> 10;
  endfunction

  task automatic predict_vertex(logic signed [15:0] x, logic signed [15:0] y, logic lst);
    longint cx, cy, dx, dy, rx, ry;
    rot_point_t p;
    if (shape_n < MaxVerts) begin
      shape_x[shape_n] = x;
      shape_y[shape_n] = y;
      shape_n++;
      acc_x += x;
      acc_y += y;
    end else begin
      shape_dropped = 1'b1;
    end
    if (lst) begin
      if (shape_n > 0) begin
        cx = acc_x / shape_n;
        cy = acc_y / shape_n;
        for (int i = 0; i < shape_n; i++) begin
          dx = longint'(shape_x[i]) - cx;
          dy = longint'(shape_y[i]) - cy;
          rx = dx * cos_val - dy * sin_val;
          ry = dx * sin_val + dy * cos_val;
          p.x = sat22(q14_round(rx) + cx * 16);
          p.y = sat22(q14_round(ry) + cy * 16);
          p.last = (i == shape_n - 1);
          p.ovf = shape_dropped;
          rotated_q = {rotated_q, p};
        end
      end
      shape_n = 0;
      acc_x = 0;
      acc_y = 0;
      shape_dropped = 1'b0;
    end
  endtask

  // Sends one vertex request and holds it until the block accepts it.
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, logic lst);
    in_valid = 1'b1;
    x_in = x;
    y_in = y;
    last_in = lst;
    do @(posedge clk); while (in_stall);
    predict_vertex(x, y, lst);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain();
    while (rotated_q.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(rpc_cfg_idx_t idx, logic signed [15:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_COS) cos_val = val; else sin_val = val;
  endtask

  task automatic send_shape(int n, int range_sel);
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      case (range_sel)
        0: begin
          x = 16'($urandom_range(0, 400)) - 16'sd200;
          y = 16'($urandom_range(0, 400)) - 16'sd200;
        end
        1: begin
          x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end
        default: begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
      endcase
      send_vertex(x, y, i == n - 1);
      maybe_gap();
    end
    shapes_sent++;
  endtask

  always @(posedge clk) begin
    rot_point_t e;
    if (!rst && out_valid && !out_stall) begin
      points_seen++;
      if (rotated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result x=%0d y=%0d", x_out, y_out);
      end else begin
        e = rotated_q.pop_front();
        if (e.x !== x_out || e.y !== y_out || e.last !== last_out || e.ovf !== overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp x=%0d y=%0d last=%0b ovf=%0b, got x=%0d y=%0d last=%0b ovf=%0b",
                     e.x, e.y, e.last, e.ovf, x_out, y_out, last_out, overflow);
        end
      end
    end
  end

  // Receiver stall pattern, or a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (rand_stall_en) begin
      out_stall <= ($urandom_range(0, 2) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_directed();
    send_vertex(16'sh7fff, 16'sh7fff, 1'b1);
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh8000, 1'b0);
    send_vertex(16'sd0, 16'sd0, 1'b1);
    send_vertex(16'sd3, -16'sd5, 1'b0);
    send_vertex(-16'sd4, 16'sd7, 1'b0);
    send_vertex(16'sd1, 16'sd1, 1'b1);
    drain();
    write_reg(CFG_COS, 16'sd0);
    write_reg(CFG_SIN, 16'sd16384);
    send_vertex(16'sh8000, 16'sh7fff, 1'b0);
    send_vertex(16'sh7fff, 16'sh8000, 1'b0);
    send_vertex(-16'sd1, 16'sd2, 1'b1);
    drain();
  endtask

  task automatic test_extreme_regs();
    write_reg(CFG_COS, 16'sh8000);
    write_reg(CFG_SIN, 16'sh7fff);
    send_shape(4, 1);
    send_shape(3, 2);
    drain();
    write_reg(CFG_COS, -16'sd16384);
    write_reg(CFG_SIN, -16'sd16384);
    send_shape(5, 2);
    drain();
  endtask

  task automatic test_store_full();
    write_reg(CFG_COS, 16'sd11585);
    write_reg(CFG_SIN, 16'sd11585);
    send_shape(MaxVerts + 3, 0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    send_shape(8, 0);
    send_shape(12, 2);
    drain();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    rand_stall_en = 1'b1;
    while (sent < 90) begin
      int n;
      if (shapes_sent % 4 == 0) begin
        drain();
        write_reg(CFG_COS, 16'($urandom_range(0, 32768)) - 16'sd16384);
        write_reg(CFG_SIN, 16'($urandom_range(0, 32768)) - 16'sd16384);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MaxVerts + 2) : $urandom_range(1, 8);
      send_shape(n, $urandom_range(0, 2));
      sent += n;
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = CFG_COS;
    cfg_data = '0;
    in_valid = 1'b0;
    x_in = '0;
    y_in = '0;
    last_in = 1'b0;
    out_stall = 1'b0;
    hold_cycles = 0;
    rand_stall_en = 1'b0;
    mismatches = 0;
    points_seen = 0;
    shapes_sent = 0;
    shape_n = 0;
    acc_x = 0;
    acc_y = 0;
    shape_dropped = 1'b0;
    cos_val = 16'sd16384;
    sin_val = 16'sd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_extreme_regs();
    test_store_full();
    test_backpressure();
    test_random();

    $display("Covered %0d shapes and %0d rotated points, including full stores and long stalls.",
             shapes_sent, points_seen);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, rotated_q.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* rotate_points_about_centroid_core.f */
sv/rpc_pkg.sv
sv/rpc_ctrl.sv
sv/rpc_dp.sv
sv/rotate_points_about_centroid_core.sv
bench/tb.sv
